FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file cscc_checker.sv.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CSCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cscc_pkg.sv
// Shared types, widths and calibration constants of the capacitance readout.
// No dependencies; used by the top level, cscc_core and cscc_alu.
package cscc_pkg;

	localparam int CH_N       = 4;
	localparam int CH_W       = 2;
	localparam int COUNT_BITS = 28;
	localparam int CAP_FRAC   = 16;
	localparam int FREQ_SHIFT = 28;
	localparam int FREQ_W     = 26;
	localparam int REFCLK_W   = 26;
	localparam int DIV_W      = 10;
	localparam int CAP_W      = 32;
	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int DW         = 144;            // shared unit and work registers
	localparam int MW         = 64;             // multiplier / quotient register
	localparam int CNT_W      = 6;
	localparam int F2_W       = 2 * FREQ_W;
	localparam int DD_W       = 45;             // covers every |f0^2 - f1^2| below
	localparam int QBITS      = 42;             // quotient bits, saturation at 2^40
	localparam int MAG_BITS   = 40;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// steps of each pass of the shared unit
	localparam int MUL1_N = REFCLK_W;
	localparam int FDIV_N = COUNT_BITS + REFCLK_W + 1 - FREQ_SHIFT;
	localparam int SQ_N   = FREQ_W;
	localparam int DEN_N  = DD_W;
	localparam int NUM_N  = F2_W;
	localparam int QDIV_N = QBITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFCLK = 3'd0,
		REG_HALVE  = 3'd1,
		REG_DIV0   = 3'd2,
		REG_DIV1   = 3'd3,
		REG_DIV2   = 3'd4,
		REG_DIV3   = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_FDIV,
		ST_SQ,
		ST_DEN,
		ST_NUM,
		ST_NADD,
		ST_QDIV,
		ST_DONE
	} core_state_t;

	typedef struct packed {
		logic [CH_W-1:0]       ch;
		logic [COUNT_BITS-1:0] count;
		logic                  halve;
		logic [DIV_W-1:0]      div;
		logic [REFCLK_W-1:0]   refclk;
	} core_req_t;

	typedef struct packed {
		logic                    done;
		logic [FREQ_W-1:0]       freq;
		logic signed [CAP_W-1:0] cap;
	} core_res_t;

	// calibration points per channel: f0 Hz, C0 pF, f1 Hz, C1 pF
	localparam longint CAL_F0 [CH_N] = '{64'd5236724, 64'd5327747, 64'd5294127, 64'd5284759};
	localparam longint CAL_C0 [CH_N] = '{64'd0, 64'd0, 64'd0, 64'd0};
	localparam longint CAL_F1 [CH_N] = '{64'd3567490, 64'd3593115, 64'd3621911, 64'd3581204};
	localparam longint CAL_C1 [CH_N] = '{64'd56, 64'd56, 64'd56, 64'd56};

	function automatic logic [63:0] f0sq_of(int c);
		return 64'(CAL_F0[c] * CAL_F0[c]);
	endfunction

	function automatic logic [63:0] dd_of(int c);
		longint a;
		longint b;
		a = CAL_F0[c] * CAL_F0[c];
		b = CAL_F1[c] * CAL_F1[c];
		return (a >= b) ? 64'(a - b) : 64'(b - a);
	endfunction

	function automatic logic neg_of(int c);
		return (CAL_C1[c] < CAL_C0[c]) ^ (CAL_F0[c] * CAL_F0[c] < CAL_F1[c] * CAL_F1[c]);
	endfunction

	function automatic logic [127:0] k_of(int c);
		longint dc;
		dc = (CAL_C1[c] >= CAL_C0[c]) ? CAL_C1[c] - CAL_C0[c] : CAL_C0[c] - CAL_C1[c];
		return (128'(dc) << CAP_FRAC) * 128'(CAL_F1[c] * CAL_F1[c]);
	endfunction

	function automatic logic [63:0] base_of(int c);
		return 64'(CAL_C0[c] * (64'sd1 <<< CAP_FRAC));
	endfunction

	localparam logic [63:0]  CAL_F0SQ [CH_N] = '{f0sq_of(0), f0sq_of(1), f0sq_of(2), f0sq_of(3)};
	localparam logic [63:0]  CAL_DD   [CH_N] = '{dd_of(0), dd_of(1), dd_of(2), dd_of(3)};
	localparam logic         CAL_NEG  [CH_N] = '{neg_of(0), neg_of(1), neg_of(2), neg_of(3)};
	localparam logic [127:0] CAL_K    [CH_N] = '{k_of(0), k_of(1), k_of(2), k_of(3)};
	localparam logic [63:0]  CAL_BASE [CH_N] = '{base_of(0), base_of(1), base_of(2), base_of(3)};

	function automatic logic [OUT_DATA_W-1:0] pack_out(
		logic [CH_W-1:0] ch, logic [FREQ_W-1:0] f, logic [CAP_W-1:0] cap,
		logic rdy, logic aw, logic wd, logic [MASK_W-1:0] mask);
		return {5'd0, mask, wd, aw, rdy, cap, f, ch};
	endfunction

endpackage

FILE: rtl/capacitive_sensor_count_to_capacitance_top.sv
// Top level of the capacitance readout: stream ports, registers, new-data mask.
// Depends on cscc_pkg and cscc_core.
//
// channel  dir  fields
// s_*      in   tuser: operation; tdata: channel, data_high, data_low, clear_mask
// m_*      out  tdata: result_channel .. new_data_mask
// cfg_*    in   plain register write, index 0..5
//
// A sample runs the bit-serial passes of the one shared adder/subtractor:
// multiply, frequency divide, square, denominator, numerator, add, quotient
// divide, then finish and output register; a zero frequency skips all after the divide.
// s_tready is low while a sample is in work or a result or clear item is pending.
// Reset sets the config defaults and clears mask and valid flags, not data registers.
module capacitive_sensor_count_to_capacitance_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cscc_pkg::IN_DATA_W-1:0]      s_tdata,  // channel, data_high, data_low, clear_mask
	input  logic                                s_tuser,  // operation
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// result_channel, frequency_hz, capacitance_q16, ready_res, amplitude_warning,
	// watchdog_error, new_data_mask
	output logic [cscc_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [cscc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cscc_pkg::REFCLK_W-1:0]       cfg_wdata
);
	import cscc_pkg::*;

	logic [REFCLK_W-1:0] refclk_q;
	logic [CH_N-1:0]     halve_q;
	logic [DIV_W-1:0]    div_q [CH_N];
	logic [MASK_W-1:0]   mask_q;

	logic [CH_W-1:0]     ch_q;
	logic                aw_q, wd_q;
	logic [MASK_W-1:0]   rmask_q;

	logic                  pend_valid_q;
	logic [OUT_DATA_W-1:0] pend_q;

	logic                  core_idle;
	core_req_t             req;
	core_res_t             res;

	logic [CH_W-1:0]       in_ch;
	logic [15:0]           in_hi, in_lo;
	logic [MASK_W-1:0]     in_clr;
	logic                  accept, take_out;
	logic [MASK_W-1:0]     mask_set;

	assign in_ch  = s_tdata[1:0];
	assign in_hi  = s_tdata[17:2];
	assign in_lo  = s_tdata[33:18];
	assign in_clr = s_tdata[37:34];

	assign s_tready = core_idle && !pend_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign take_out = !m_tvalid || m_tready;
	assign mask_set = mask_q | (MASK_W'(1) << in_ch);

	assign req.ch     = in_ch;
	assign req.count  = {in_hi[11:0], in_lo};
	assign req.halve  = halve_q[in_ch];
	assign req.div    = div_q[in_ch];
	assign req.refclk = refclk_q;

	cscc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !s_tuser),
		.req    (req),
		.idle   (core_idle),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refclk_q <= REFCLK_W'(16000000);
			halve_q  <= '0;
			for (int i = 0; i < CH_N; i++) div_q[i] <= DIV_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REFCLK: refclk_q <= cfg_wdata;
				REG_HALVE:  halve_q  <= cfg_wdata[CH_N-1:0];
				REG_DIV0:   div_q[0] <= cfg_wdata[DIV_W-1:0];
				REG_DIV1:   div_q[1] <= cfg_wdata[DIV_W-1:0];
				REG_DIV2:   div_q[2] <= cfg_wdata[DIV_W-1:0];
				REG_DIV3:   div_q[3] <= cfg_wdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// sample flags and mask travel beside the core until its result is back
	always_ff @(posedge clk) begin
		if (accept && !s_tuser) begin
			ch_q    <= in_ch;
			aw_q    <= in_hi[12];
			wd_q    <= in_hi[13];
			rmask_q <= mask_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '0;
			pend_valid_q <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			if (accept) begin
				if (s_tuser) begin
					mask_q       <= mask_q & ~in_clr;
					pend_valid_q <= 1'b1;
				end else begin
					mask_q <= mask_set;
				end
			end
			if (res.done) pend_valid_q <= 1'b1;
			if (take_out) begin
				m_tvalid <= pend_valid_q;
				if (pend_valid_q) pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser)
			pend_q <= pack_out('0, '0, '0, 1'b0, 1'b0, 1'b0, mask_q & ~in_clr);
		else if (res.done)
			pend_q <= pack_out(ch_q, res.freq, res.cap, !(aw_q || wd_q), aw_q, wd_q, rmask_q);
		if (take_out && pend_valid_q)
			m_tdata <= pend_q;
	end

endmodule

FILE: rtl/cscc_alu.sv
// Shared wide adder/subtractor of the readout datapath.
// Depends on cscc_pkg for the datapath width.
module cscc_alu (
	input  logic [cscc_pkg::DW-1:0] a,
	input  logic [cscc_pkg::DW-1:0] b,
	input  logic                    sub,
	output logic [cscc_pkg::DW-1:0] y,
	output logic                    borrow
);
	import cscc_pkg::*;

	logic [DW:0] sum;

	assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (DW+1)'(sub);
	assign y      = sum[DW-1:0];
	assign borrow = sub & ~sum[DW];

endmodule

FILE: rtl/cscc_core.sv
// Sequencer and work registers: frequency and capacitance of one sample.
// Depends on cscc_pkg and cscc_alu (one shared add/subtract unit).
module cscc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  cscc_pkg::core_req_t    req,
	output logic                   idle,
	output cscc_pkg::core_res_t    res
);
	import cscc_pkg::*;

	core_state_t state_q, state_d;

	logic [DW-1:0]       acc_q, mcand_q, den_q;
	logic [MW-1:0]       mplier_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CH_W-1:0]     ch_q;
	logic [DIV_W-1:0]    div_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [F2_W-1:0]     dn_q;
	logic                n2_q;
	logic [CAP_W-1:0]    cap_q;

	logic [DW-1:0]       alu_b, alu_y;
	logic                alu_sub, alu_borrow;
	logic [DW-1:0]       mul_next, div_acc;
	logic                qbit;
	logic                last;
	logic [FDIV_N-1:0]   fq;
	logic [FREQ_W-1:0]   f_next;
	logic [F2_W-1:0]     f2;
	logic [F2_W-1:0]     f0sq;
	logic [QBITS-1:0]    qq;
	logic [QBITS-1:0]    mag;
	logic signed [63:0]  v;
	logic [CAP_W-1:0]    cap_next;
	logic                skip_cap;

	cscc_alu u_alu (
		.a      (acc_q),
		.b      (alu_b),
		.sub    (alu_sub),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	assign mul_next = mplier_q[0] ? alu_y : acc_q;
	assign qbit     = ~alu_borrow;
	assign div_acc  = qbit ? alu_y : acc_q;

	assign fq       = {mplier_q[FDIV_N-2:0], qbit};
	assign f_next   = fq[FDIV_N-1] ? {FREQ_W{1'b1}} : fq[FREQ_W-1:0];
	assign skip_cap = (f_next == '0) || (CAL_DD[ch_q] == '0);

	assign f2   = mul_next[F2_W-1:0];
	assign f0sq = F2_W'(CAL_F0SQ[ch_q]);

	// capacitance from the quotient: saturate magnitude, apply sign, clamp
	always_comb begin
		qq  = {mplier_q[QBITS-2:0], qbit};
		mag = (qq > (QBITS'(1) << MAG_BITS)) ? (QBITS'(1) << MAG_BITS) : qq;
		if (CAL_NEG[ch_q] ^ n2_q)
			v = $signed(CAL_BASE[ch_q]) - $signed(64'(mag));
		else
			v = $signed(CAL_BASE[ch_q]) + $signed(64'(mag));
		if (v > 64'sd2147483647)
			cap_next = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			cap_next = 32'h8000_0000;
		else
			cap_next = v[CAP_W-1:0];
	end

	// outputs of the sequencer: shared unit control and step end
	always_comb begin
		alu_b   = mcand_q;
		alu_sub = 1'b0;
		last    = 1'b0;
		unique case (state_q)
			ST_MUL1: last = (cnt_q == CNT_W'(MUL1_N - 1));
			ST_FDIV: begin
				alu_sub = 1'b1;
				last    = (cnt_q == CNT_W'(FDIV_N - 1));
			end
			ST_SQ:   last = (cnt_q == CNT_W'(SQ_N - 1));
			ST_DEN:  last = (cnt_q == CNT_W'(DEN_N - 1));
			ST_NUM:  last = (cnt_q == CNT_W'(NUM_N - 1));
			ST_NADD: alu_b = den_q;
			ST_QDIV: begin
				alu_sub = 1'b1;
				last    = (cnt_q == CNT_W'(QDIV_N - 1));
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_MUL1;
			ST_MUL1: if (last) state_d = ST_FDIV;
			ST_FDIV: if (last) state_d = skip_cap ? ST_DONE : ST_SQ;
			ST_SQ:   if (last) state_d = ST_DEN;
			ST_DEN:  if (last) state_d = ST_NUM;
			ST_NUM:  if (last) state_d = ST_NADD;
			ST_NADD: state_d = ST_QDIV;
			ST_QDIV: if (last) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE || last || state_q == ST_NADD)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				ch_q     <= req.ch;
				div_q    <= (req.div == '0) ? DIV_W'(1) : req.div;
				acc_q    <= '0;
				mcand_q  <= DW'(req.count) << req.halve;
				mplier_q <= MW'(req.refclk);
			end
			ST_MUL1, ST_SQ, ST_DEN, ST_NUM: begin
				acc_q    <= mul_next;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				if (last) begin
					mplier_q <= '0;
					acc_q    <= '0;
					unique case (state_q)
						ST_MUL1: begin
							acc_q   <= mul_next >> FREQ_SHIFT;
							mcand_q <= DW'(div_q) << (FDIV_N - 1);
						end
						ST_SQ: begin
							// |f0^2 - f^2| and its sign, then f^2 * |f0^2 - f1^2|
							n2_q     <= (f0sq < f2);
							dn_q     <= (f0sq < f2) ? (f2 - f0sq) : (f0sq - f2);
							mcand_q  <= DW'(f2);
							mplier_q <= MW'(CAL_DD[ch_q]);
						end
						ST_DEN: begin
							den_q    <= mul_next;
							mcand_q  <= DW'(CAL_K[ch_q]);
							mplier_q <= MW'(dn_q);
						end
						default: acc_q <= mul_next << 1;
					endcase
				end
			end
			ST_FDIV: begin
				acc_q    <= div_acc;
				mcand_q  <= mcand_q >> 1;
				mplier_q <= {mplier_q[MW-2:0], qbit};
				if (last) begin
					freq_q   <= f_next;
					cap_q    <= (f_next == '0) ? 32'h7FFF_FFFF : CAL_BASE[ch_q][CAP_W-1:0];
					acc_q    <= '0;
					mcand_q  <= DW'(f_next);
					mplier_q <= MW'(f_next);
				end
			end
			ST_NADD: begin
				// numerator 2*num + den, divisor 2*den aligned to the top quotient bit
				acc_q    <= alu_y;
				mcand_q  <= den_q << QBITS;
				mplier_q <= '0;
			end
			ST_QDIV: begin
				acc_q    <= div_acc;
				mcand_q  <= mcand_q >> 1;
				mplier_q <= {mplier_q[MW-2:0], qbit};
				if (last) cap_q <= cap_next;
			end
			default: ;
		endcase
	end

	assign idle     = (state_q == ST_IDLE);
	assign res.done = (state_q == ST_DONE);
	assign res.freq = freq_q;
	assign res.cap  = cap_q;

endmodule

FILE: rtl/cscc_checker.sv
// Port-level checks of the capacitance readout, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cscc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	`CSCC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	`CSCC_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

	`CSCC_ASSERT_NOW(a_ready_flag, m_tvalid && (m_tdata[61] || m_tdata[62]), !m_tdata[60], "ready set with a flag")

	`CSCC_ASSERT_NXT(a_busy_after_sample, s_tvalid && s_tready && !s_tuser, !s_tready, "input open during a sample")

endmodule

bind capacitive_sensor_count_to_capacitance_top cscc_checker u_cscc_checker (.*);
